// ===== hw/rtl/bbc_pkg.sv =====
// Shared types, constants and codes of the buffer cache tag store.
package bbc_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_HIT    = 3'd0,
    STS_READ   = 3'd1,
    STS_NOFREE = 3'd2,
    STS_FAULT  = 3'd3,
    STS_DONE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_FETCH,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic [31:0] stamp;
    logic        valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic fetch_rd;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_acquire;
    logic scan_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bbc_ctrl.sv =====
// Controller state machine: sequences the slot scan, the target fetch and the update.
module bbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bbc_pkg::dp_stat_t   stat,
  output bbc_pkg::ctrl_cmd_t  cmd
);
  import bbc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          // The op is decided from the port here, since the register loads at this edge.
          state_next = stat.is_acquire ? S_SCAN : S_FETCH;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // Last scan read lands this cycle; the trackers settle at its end.
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch_rd = 1'b1;
        state_next   = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bbc_datapath.sv =====
// Datapath: slot store, scan trackers for tag match and oldest free slot, update and result.
module bbc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  bbc_pkg::ctrl_cmd_t           cmd,
  output bbc_pkg::dp_stat_t            stat,
  input  logic [1:0]                   op,
  input  logic [7:0]                   device,
  input  logic [31:0]                  block_number,
  input  logic [4:0]                   slot_index,
  input  logic [31:0]                  now_tick,
  output logic                         done,
  output logic [2:0]                   status,
  output logic [4:0]                   result_slot,
  output logic [7:0]                   ref_count
);
  import bbc_pkg::*;

  // Latched request.
  op_t         op_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  slot_q;
  logic [31:0] now_q;

  // Scan state.
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] rd_idx;
  logic              scan_live;
  logic              match_found;
  logic [SLOT_W-1:0] match_idx;
  logic              free_found;
  logic [SLOT_W-1:0] victim_idx;
  logic [31:0]       best_stamp;

  // Store access.
  logic [SLOT_COUNT-1:0] seen;
  logic                  seen_rd;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                entry;
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     target_addr;
  logic                  we;
  entry_t                wentry;

  logic        hit_now;
  logic        free_better;
  logic        slot_in_range;
  status_t     res_status;
  logic [SLOT_W-1:0] res_idx;
  logic [4:0]  res_slot;
  logic [7:0]  res_cnt;

  assign stat.is_acquire = (op_t'(op) == OP_ACQUIRE);
  assign stat.scan_last  = (scan_addr == SLOT_W'(SLOT_COUNT - 1));

  // A slot never written since reset reads as all zero.
  assign entry = seen_rd ? entry_t'(ram_rdata) : '0;

  assign slot_in_range = (32'(slot_q) < 32'(SLOT_COUNT));

  always_comb begin
    if (op_q != OP_ACQUIRE) begin
      target_addr = SLOT_W'(slot_q);
    end else if (match_found) begin
      target_addr = match_idx;
    end else begin
      target_addr = victim_idx;
    end
  end

  assign rd_en   = cmd.scan_rd | cmd.fetch_rd;
  assign rd_addr = cmd.scan_rd ? scan_addr : target_addr;

  bbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (target_addr),
    .wdata (wentry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(op);
      dev_q  <= device;
      blk_q  <= block_number;
      slot_q <= slot_index;
      now_q  <= now_tick;
    end
    if (rd_en) begin
      seen_rd <= seen[rd_addr];
    end
    rd_idx <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (we) begin
      seen[target_addr] <= 1'b1;
    end
  end

  // Scan: one slot read per cycle, evaluated in the cycle after its read.
  assign hit_now     = (entry.dev == dev_q) && (entry.blk == blk_q);
  assign free_better = (entry.cnt == 8'd0) && (!free_found || (entry.stamp < best_stamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_live   <= 1'b0;
      scan_addr   <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      match_idx   <= '0;
      victim_idx  <= '0;
      best_stamp  <= '0;
    end else begin
      scan_live <= cmd.scan_rd;
      if (cmd.load) begin
        scan_addr   <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        match_idx   <= '0;
        victim_idx  <= '0;
      end else begin
        if (cmd.scan_rd) begin
          scan_addr <= scan_addr + SLOT_W'(1);
        end
        if (scan_live) begin
          if (!match_found && hit_now) begin
            match_found <= 1'b1;
            match_idx   <= rd_idx;
          end
          if (free_better) begin
            free_found <= 1'b1;
            victim_idx <= rd_idx;
            best_stamp <= entry.stamp;
          end
        end
      end
    end
  end

  // Update of the fetched target slot and the result of the operation.
  always_comb begin
    we         = 1'b0;
    wentry     = entry;
    res_status = STS_DONE;
    res_idx    = target_addr;
    res_cnt    = 8'd0;
    if (op_q == OP_ACQUIRE) begin
      if (match_found) begin
        if (entry.cnt == CNT_MAX) begin
          res_status = STS_FAULT;
          res_cnt    = CNT_MAX;
        end else begin
          we           = cmd.apply;
          wentry.cnt   = entry.cnt + 8'd1;
          wentry.valid = 1'b1;
          res_status   = entry.valid ? STS_HIT : STS_READ;
          res_cnt      = entry.cnt + 8'd1;
        end
      end else if (free_found) begin
        we           = cmd.apply;
        wentry.dev   = dev_q;
        wentry.blk   = blk_q;
        wentry.cnt   = 8'd1;
        wentry.valid = 1'b1;
        res_status   = STS_READ;
        res_cnt      = 8'd1;
      end else begin
        res_status = STS_NOFREE;
        res_idx    = '0;
      end
    end else if (!slot_in_range) begin
      res_status = STS_DONE;
    end else if (op_q == OP_PIN) begin
      if (entry.cnt == CNT_MAX) begin
        res_status = STS_FAULT;
        res_cnt    = CNT_MAX;
      end else begin
        we         = cmd.apply;
        wentry.cnt = entry.cnt + 8'd1;
        res_cnt    = entry.cnt + 8'd1;
      end
    end else begin
      if (entry.cnt == 8'd0) begin
        res_status = STS_FAULT;
      end else begin
        we         = cmd.apply;
        wentry.cnt = entry.cnt - 8'd1;
        res_cnt    = entry.cnt - 8'd1;
        // Only a release that drops the last reference records the tick.
        if ((op_q == OP_RELEASE) && (entry.cnt == 8'd1)) begin
          wentry.stamp = now_q;
        end
      end
    end
  end

  // Out-of-range slots report the index as given rather than the truncated address.
  assign res_slot = ((op_q != OP_ACQUIRE) && !slot_in_range) ? slot_q : 5'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.apply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status      <= res_status;
      result_slot <= res_slot;
      ref_count   <= res_cnt;
    end
  end

endmodule

// ===== hw/rtl/block_buffer_cache_lru_refcount.sv =====
// Top level of the buffer cache tag store with reference counts and LRU replacement.
//
//   Channel   Handshake            Fields
//   request   start / busy         op, device, block_number, slot_index, now_tick
//   result    done (one cycle)     status, result_slot, ref_count
//
// A request transfer happens at an edge with start high and busy low.
// An acquire reads every slot once through the single read port of the slot
// store, then fetches and updates the chosen slot. Release, pin and unpin
// skip the scan and fetch and update the given slot directly.
// done pulses for one cycle; busy drops in that same cycle, so a new request
// may be taken while the result is shown. The receiver cannot stall.
// rst (synchronous) marks every slot as unwritten, which reads as all zero.
module block_buffer_cache_lru_refcount (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  slot_index,
  input  logic [31:0] now_tick,
  output logic        done,
  output logic [2:0]  status,
  output logic [4:0]  result_slot,
  output logic [7:0]  ref_count
);
  import bbc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bbc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .device       (device),
    .block_number (block_number),
    .slot_index   (slot_index),
    .now_tick     (now_tick),
    .done         (done),
    .status       (status),
    .result_slot  (result_slot),
    .ref_count    (ref_count)
  );

endmodule
